FILE: src/cfl_pkg.sv
// ----------------------------------------------------------------------------
// cfl_pkg: shared types and constants
// Item and segment entry layouts and register indexes for the format-4
// character map lookup block.
// ----------------------------------------------------------------------------
package cfl_pkg;

   localparam logic [1:0] OP_LOAD_SEG   = 2'd0;
   localparam logic [1:0] OP_LOAD_GLYPH = 2'd1;
   localparam logic [1:0] OP_CODE2GLYPH = 2'd2;
   localparam logic [1:0] OP_GLYPH2CODE = 2'd3;

   localparam logic CSR_SEGMENT_COUNT = 1'b0;
   localparam logic CSR_GLYPH_COUNT   = 1'b1;

   typedef struct packed {
      logic [1:0]  operation;
      logic [12:0] entry_index;
      logic [15:0] start_code;
      logic [15:0] end_code;
      logic [15:0] id_delta;
      logic [15:0] range_offset;
      logic [15:0] glyph_word;
      logic [15:0] query;
   } item_type;

   typedef struct packed {
      logic [15:0] start_code;
      logic [15:0] end_code;
      logic [15:0] id_delta;
      logic        table_mode;
      logic [14:0] base;
   } seg_type;

endpackage

FILE: src/cmap_format4_lookup.sv
// ----------------------------------------------------------------------------
// cmap_format4_lookup: TrueType format-4 character map lookup
// Segment table and glyph store with forward and reverse lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_* and raise start; an item is taken at a clock
//   edge where start is high and busy is low. Items land in a two-entry queue,
//   busy rises only while that queue is full.
//   Response channel: exactly one result per item, shown for one cycle with
//   rsp_valid high. The receiver cannot stall; it must take every strobe.
//   CSR port: csr_write_enable with csr_index 0 (segment count) or 1 (glyph
//   count); write only while no item is outstanding.
//   Steps: a load writes its store in S_EXEC and answers there. A lookup scans
//   the segments in order, each with a segment RAM read (S_SREAD) and a compare
//   (S_SCHK); a table-mode forward match then reads its glyph word (S_FWAIT).
//   A reverse lookup also walks the glyph words of a table-mode segment
//   (S_GREAD, S_GCHK) and leaves through S_GREAD when the walk found nothing.
//   The back part runs one item at a time; it pops no new item until the last is done.
//   Reset: clears the queue and sequencer, segment count 1, glyph count 0.
//   Store contents are undefined until written.
// ----------------------------------------------------------------------------
module cmap_format4_lookup #(
   parameter int MAX_SEGMENTS    = 256,
   parameter int MAX_GLYPH_WORDS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [12:0] req_entry_index,
   input  logic [15:0] req_start_code,
   input  logic [15:0] req_end_code,
   input  logic [15:0] req_id_delta,
   input  logic [15:0] req_range_offset,
   input  logic [15:0] req_glyph_word,
   input  logic [15:0] req_query,
   output logic        rsp_valid,
   output logic [15:0] rsp_result_value,
   output logic        rsp_found,
   output logic        rsp_load_error,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [12:0] csr_write_data
);
   import cfl_pkg::*;

   logic [8:0]  segment_count_ff;
   logic [12:0] glyph_count_ff;
   item_type    req_item;
   item_type    q_item;
   logic        q_empty;
   logic        q_pop;

   // Hold the configuration registers; take writes at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         segment_count_ff <= 9'd1;
         glyph_count_ff   <= 13'd0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SEGMENT_COUNT: segment_count_ff <= csr_write_data[8:0];
            CSR_GLYPH_COUNT:   glyph_count_ff   <= csr_write_data;
            default:           glyph_count_ff   <= glyph_count_ff;
         endcase
      end
   end

   always_comb begin
      req_item.operation    = req_operation;
      req_item.entry_index  = req_entry_index;
      req_item.start_code   = req_start_code;
      req_item.end_code     = req_end_code;
      req_item.id_delta     = req_id_delta;
      req_item.range_offset = req_range_offset;
      req_item.glyph_word   = req_glyph_word;
      req_item.query        = req_query;
   end

   // Front: accept and queue each item.
   cfl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .in_item  (req_item),
      .pop      (q_pop),
      .empty    (q_empty),
      .out_item (q_item)
   );

   // Back: load the stores and run the scans.
   cfl_back #(
      .MAX_SEGMENTS    (MAX_SEGMENTS),
      .MAX_GLYPH_WORDS (MAX_GLYPH_WORDS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .segment_count    (segment_count_ff),
      .glyph_count      (glyph_count_ff),
      .rsp_valid        (rsp_valid),
      .rsp_result_value (rsp_result_value),
      .rsp_found        (rsp_found),
      .rsp_load_error   (rsp_load_error)
   );
endmodule

FILE: src/cfl_ram.sv
// ----------------------------------------------------------------------------
// cfl_ram: generic single-port-write, registered-read RAM
// One write and one read per cycle; read data held until the next read.
// ----------------------------------------------------------------------------
module cfl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                                    clock,
   input  logic                                    write_enable,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] write_addr,
   input  logic [WIDTH-1:0]                        write_data,
   input  logic                                    read_enable,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] read_addr,
   output logic [WIDTH-1:0]                        read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;
endmodule

FILE: src/cfl_front.sv
// ----------------------------------------------------------------------------
// cfl_front: request intake
// Capture items into a two-entry queue; raise busy while it is full.
// ----------------------------------------------------------------------------
module cfl_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cfl_pkg::item_type in_item,
   input  logic              pop,
   output logic              empty,
   output cfl_pkg::item_type out_item
);
   import cfl_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       do_pop;

   assign busy     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign push     = start && !busy;
   assign do_pop   = pop && !empty;
   assign out_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end
endmodule

FILE: src/cfl_back.sv
// ----------------------------------------------------------------------------
// cfl_back: execution sequencer
// Pop items, perform loads and segment/glyph scans over the two stores.
// ----------------------------------------------------------------------------
module cfl_back #(
   parameter int MAX_SEGMENTS    = 256,
   parameter int MAX_GLYPH_WORDS = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  cfl_pkg::item_type q_item,
   output logic              q_pop,
   input  logic [8:0]        segment_count,
   input  logic [12:0]       glyph_count,
   output logic              rsp_valid,
   output logic [15:0]       rsp_result_value,
   output logic              rsp_found,
   output logic              rsp_load_error
);
   import cfl_pkg::*;

   localparam int SEG_AW = MAX_SEGMENTS > 1 ? $clog2(MAX_SEGMENTS) : 1;
   localparam int SEG_CW = $clog2(MAX_SEGMENTS + 1);
   localparam int GLY_AW = MAX_GLYPH_WORDS > 1 ? $clog2(MAX_GLYPH_WORDS) : 1;
   localparam int SEG_W  = $bits(seg_type);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_SREAD = 3'd2;
   localparam logic [2:0] S_SCHK  = 3'd3;
   localparam logic [2:0] S_FWAIT = 3'd4;
   localparam logic [2:0] S_GREAD = 3'd5;
   localparam logic [2:0] S_GCHK  = 3'd6;

   logic [2:0]        state_ff, state_in;
   item_type          cur_ff, cur_in;
   logic [SEG_CW-1:0] seg_ptr_ff, seg_ptr_in;
   logic [16:0]       gp_ff, gp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_value_ff, rsp_value_in;
   logic              rsp_found_ff, rsp_found_in;
   logic              rsp_err_ff, rsp_err_in;

   logic [SEG_CW-1:0] seg_n;
   logic [SEG_CW-1:0] seg_next;
   int                glyph_n;

   logic              seg_we, seg_re;
   logic [SEG_AW-1:0] seg_waddr, seg_raddr;
   seg_type           seg_wdata, seg_rd;
   logic [SEG_W-1:0]  seg_rdata;
   logic              gly_we, gly_re;
   logic [GLY_AW-1:0] gly_waddr, gly_raddr;
   logic [15:0]       gly_rdata;

   logic [15:0]        sub;
   logic [15:0]        rebase_t;
   logic signed [18:0] last_idx;
   logic [16:0]        fwd_idx;
   logic [15:0]        rev_code;
   logic [16:0]        walk_last;

   assign seg_n   = (32'(segment_count) < MAX_SEGMENTS) ? SEG_CW'(segment_count)
                                                         : SEG_CW'(MAX_SEGMENTS);
   assign glyph_n = (32'(glyph_count) < MAX_GLYPH_WORDS) ? int'(glyph_count)
                                                          : MAX_GLYPH_WORDS;
   assign seg_next = seg_ptr_ff + SEG_CW'(1);
   assign seg_rd   = seg_type'(seg_rdata);

   cfl_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
      .clock        (clock),
      .write_enable (seg_we),
      .write_addr   (seg_waddr),
      .write_data   (SEG_W'(seg_wdata)),
      .read_enable  (seg_re),
      .read_addr    (seg_raddr),
      .read_data    (seg_rdata)
   );

   cfl_ram #(.WIDTH(16), .DEPTH(MAX_GLYPH_WORDS)) u_glyph_ram (
      .clock        (clock),
      .write_enable (gly_we),
      .write_addr   (gly_waddr),
      .write_data   (cur_ff.glyph_word),
      .read_enable  (gly_re),
      .read_addr    (gly_raddr),
      .read_data    (gly_rdata)
   );

   // Rebase the raw range offset against the segment position.
   always_comb begin
      sub      = 16'((16'(segment_count) - 16'd1 - 16'(cur_ff.entry_index)) << 1);
      rebase_t = cur_ff.range_offset - sub;
      last_idx = $signed({4'b0, rebase_t[15:1]}) + $signed({3'b0, cur_ff.end_code})
                 - $signed({3'b0, cur_ff.start_code});
      seg_wdata.start_code = cur_ff.start_code;
      seg_wdata.end_code   = cur_ff.end_code;
      seg_wdata.id_delta   = cur_ff.id_delta;
      seg_wdata.table_mode = (cur_ff.range_offset != 16'd0);
      seg_wdata.base       = (cur_ff.range_offset != 16'd0) ? rebase_t[15:1] : 15'd0;
   end

   assign fwd_idx   = 17'(seg_rd.base) + 17'(cur_ff.query - seg_rd.start_code);
   assign rev_code  = cur_ff.query - seg_rd.id_delta;
   assign walk_last = 17'(seg_rd.base) + 17'(seg_rd.end_code - seg_rd.start_code);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      seg_ptr_in   = seg_ptr_ff;
      gp_in        = gp_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_found_in = rsp_found_ff;
      rsp_err_in   = rsp_err_ff;
      q_pop        = 1'b0;
      seg_we       = 1'b0;
      seg_re       = 1'b0;
      seg_waddr    = SEG_AW'(cur_ff.entry_index);
      seg_raddr    = SEG_AW'(seg_ptr_ff);
      gly_we       = 1'b0;
      gly_re       = 1'b0;
      gly_waddr    = GLY_AW'(cur_ff.entry_index - 13'd1);
      gly_raddr    = GLY_AW'(gp_ff - 17'd1);

      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cur_in   = q_item;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rsp_value_in = 16'd0;
            rsp_found_in = 1'b0;
            rsp_err_in   = 1'b0;
            seg_ptr_in   = '0;
            unique case (cur_ff.operation)
               OP_LOAD_SEG: begin
                  if (32'(cur_ff.entry_index) < MAX_SEGMENTS) begin
                     seg_we = 1'b1;
                     if (seg_wdata.table_mode) begin
                        rsp_err_in = (seg_wdata.base == 15'd0) ||
                                     (int'(seg_wdata.base) > glyph_n) ||
                                     (int'(last_idx) > glyph_n);
                     end
                  end
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
               OP_LOAD_GLYPH: begin
                  gly_we = (cur_ff.entry_index != 13'd0) &&
                           (32'(cur_ff.entry_index) <= MAX_GLYPH_WORDS);
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
               default: begin
                  if (seg_n == '0) begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     state_in = S_SREAD;
                  end
               end
            endcase
         end
         S_SREAD: begin
            seg_re   = 1'b1;
            state_in = S_SCHK;
         end
         S_SCHK: begin
            // Default: advance to the next segment or finish unmapped.
            seg_ptr_in = seg_next;
            if (seg_next == seg_n) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_SREAD;
            end
            if (cur_ff.operation == OP_CODE2GLYPH) begin
               if (seg_rd.start_code <= cur_ff.query && cur_ff.query <= seg_rd.end_code) begin
                  seg_ptr_in = seg_ptr_ff;
                  if (!seg_rd.table_mode) begin
                     rsp_value_in = seg_rd.id_delta + cur_ff.query;
                     rsp_found_in = 1'b1;
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else if (fwd_idx == 17'd0 || int'(fwd_idx) > glyph_n) begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     // Issue the glyph word read now; the word arrives in S_FWAIT.
                     gly_re       = 1'b1;
                     gly_raddr    = GLY_AW'(fwd_idx - 17'd1);
                     gp_in        = fwd_idx;
                     rsp_valid_in = 1'b0;
                     state_in     = S_FWAIT;
                  end
               end
            end else if (!seg_rd.table_mode) begin
               if (seg_rd.start_code <= rev_code && rev_code <= seg_rd.end_code) begin
                  rsp_value_in = rev_code;
                  rsp_found_in = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end else if (seg_rd.end_code >= seg_rd.start_code) begin
               seg_ptr_in   = seg_ptr_ff;
               gp_in        = 17'(seg_rd.base);
               rsp_valid_in = 1'b0;
               state_in     = S_GREAD;
            end
         end
         S_FWAIT: begin
            if (gly_rdata != 16'd0) begin
               rsp_value_in = seg_rd.id_delta + gly_rdata;
               rsp_found_in = 1'b1;
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_GREAD: begin
            if (gp_ff > walk_last || int'(gp_ff) > glyph_n) begin
               seg_ptr_in = seg_next;
               if (seg_next == seg_n) begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_SREAD;
               end
            end else if (gp_ff == 17'd0) begin
               gp_in = gp_ff + 17'd1;
            end else begin
               gly_re   = 1'b1;
               state_in = S_GCHK;
            end
         end
         S_GCHK: begin
            if (gly_rdata != 16'd0 && cur_ff.query == 16'(seg_rd.id_delta + gly_rdata)) begin
               rsp_value_in = seg_rd.start_code + 16'(gp_ff - 17'(seg_rd.base));
               rsp_found_in = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               gp_in    = gp_ff + 17'd1;
               state_in = S_GREAD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      seg_ptr_ff   <= seg_ptr_in;
      gp_ff        <= gp_in;
      rsp_value_ff <= rsp_value_in;
      rsp_found_ff <= rsp_found_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_load_error   = rsp_err_ff;

`ifndef SYNTHESIS
   a_rsp_in_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_IDLE)
      else $error("response issued outside idle");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("back-to-back response strobes");
   a_found_no_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |-> !rsp_err_ff)
      else $error("found and load error together");
   a_seg_ptr_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SREAD |-> seg_ptr_ff < seg_n)
      else $error("segment pointer beyond segment count");
`endif
endmodule
